@@ hdl/fqs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO queue with search: shared definitions
// Modes, status codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int FQS_DEPTH  = 16;
   localparam int FQS_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_ENQ    = 2'd0,
      MODE_DEQ    = 2'd1,
      MODE_DUMP   = 2'd2,
      MODE_SEARCH = 2'd3
   } fqs_mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } fqs_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_EV,
      S_FIND,
      S_STAT
   } fqs_state_type;

   // source of the next result beat
   typedef enum logic [1:0] {
      OUT_STAT,
      OUT_DATA,
      OUT_FIND
   } fqs_out_sel_type;

   typedef struct packed {
      logic            latch;
      logic            enq_write;
      logic            walk_start;
      logic            rd_en;
      logic            step;
      logic            deq_pop;
      logic            out_load;
      fqs_out_sel_type out_sel;
   } fqs_cmd_type;

   typedef struct packed {
      logic         empty;
      logic         full;
      logic         walk_last;
      logic         out_free;
      fqs_mode_type mode;
   } fqs_stat_type;

endpackage
`default_nettype wire

@@ hdl/fqs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data. The read register
// holds its value while no read is issued.
// ----------------------------------------------------------------------------
module fqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ hdl/fqs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO queue with search: controller
// Sequences one command at a time: accept, walk the stored entries through
// the RAM read port, and hand result beats to the output register.
// ----------------------------------------------------------------------------
module fqs_ctrl
   import fqs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic [1:0]   req_mode,
   input  wire fqs_stat_type stat,
   output logic              req_stall,
   output fqs_cmd_type       cmd
);

   fqs_state_type state_ff;
   fqs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_ENQ) begin
                  if (stat.full) begin
                     state_in = S_STAT;
                  end
               end else if (stat.empty) begin
                  state_in = S_STAT;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            unique case (stat.mode)
               MODE_DEQ: begin
                  if (stat.out_free) begin
                     state_in = S_IDLE;
                  end
               end
               MODE_DUMP: begin
                  if (stat.out_free && stat.walk_last) begin
                     state_in = S_IDLE;
                  end
               end
               MODE_SEARCH: begin
                  if (stat.walk_last) begin
                     state_in = S_FIND;
                  end
               end
               MODE_ENQ: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FIND, S_STAT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.out_sel = OUT_STAT;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (req_mode == MODE_ENQ) begin
                  cmd.enq_write = !stat.full;
               end else begin
                  cmd.walk_start = !stat.empty;
               end
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
         end
         S_EV: begin
            unique case (stat.mode)
               MODE_DEQ: begin
                  if (stat.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_DATA;
                     cmd.deq_pop  = 1'b1;
                  end
               end
               MODE_DUMP: begin
                  // hold the read data until the output register frees up
                  if (stat.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_DATA;
                     cmd.step     = 1'b1;
                     cmd.rd_en    = !stat.walk_last;
                  end
               end
               MODE_SEARCH: begin
                  cmd.step  = 1'b1;
                  cmd.rd_en = !stat.walk_last;
               end
               MODE_ENQ: begin
                  cmd.step = 1'b0;
               end
            endcase
         end
         S_FIND: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_FIND;
         end
         S_STAT: begin
            cmd.out_load = stat.out_free;
            cmd.out_sel  = OUT_STAT;
         end
         default: begin
            cmd.out_sel = OUT_STAT;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/fqs_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO queue with search: datapath
// Ring pointers and fill count, the entry RAM, the walk counters for dump
// and search, and the result output register.
// ----------------------------------------------------------------------------
module fqs_dp
   import fqs_pkg::*;
#(
   parameter int DEPTH = FQS_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fqs_cmd_type                  cmd,
   input  wire logic [1:0]                   req_mode,
   input  wire logic signed [FQS_DATA_W-1:0] req_operand,
   input  wire logic                         rsp_stall,
   output fqs_stat_type                      stat,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_kind,
   output logic [1:0]                        rsp_status,
   output logic signed [FQS_DATA_W-1:0]      rsp_value,
   output logic                              rsp_found,
   output logic                              rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0]      walk_left_ff, walk_left_in;
   logic                  hit_ff, hit_in;
   fqs_mode_type          mode_ff, mode_in;
   logic [FQS_DATA_W-1:0] operand_ff, operand_in;
   fqs_status_type        code_ff, code_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [1:0]            status_ff, status_in;
   logic [FQS_DATA_W-1:0] value_ff, value_in;
   logic                  found_ff, found_in;
   logic                  last_ff, last_in;
   logic [FQS_DATA_W-1:0] rd_data;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      if (idx == IDX_W'(DEPTH - 1)) begin
         return '0;
      end
      return idx + 1'b1;
   endfunction

   fqs_ram #(
      .WIDTH (FQS_DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.enq_write),
      .wr_addr (tail_ff),
      .wr_data (req_operand),
      .rd_en   (cmd.rd_en),
      .rd_addr (walk_idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CNT_W'(DEPTH));
      stat.walk_last = (walk_left_ff == CNT_W'(1));
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
      stat.mode      = mode_ff;
   end

   // ring state
   always_comb begin
      tail_in = cmd.enq_write ? ring_next(tail_ff) : tail_ff;
      head_in = cmd.deq_pop ? ring_next(head_ff) : head_ff;
      priority if (cmd.enq_write) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.deq_pop) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   // walk over the occupied entries
   always_comb begin
      priority if (cmd.walk_start) begin
         walk_idx_in = head_ff;
      end else if (cmd.rd_en) begin
         walk_idx_in = ring_next(walk_idx_ff);
      end else begin
         walk_idx_in = walk_idx_ff;
      end
      priority if (cmd.walk_start) begin
         walk_left_in = count_ff;
         hit_in       = 1'b0;
      end else if (cmd.step) begin
         walk_left_in = walk_left_ff - 1'b1;
         hit_in       = hit_ff | (rd_data == operand_ff);
      end else begin
         walk_left_in = walk_left_ff;
         hit_in       = hit_ff;
      end
   end

   // command capture
   always_comb begin
      if (cmd.latch) begin
         mode_in    = fqs_mode_type'(req_mode);
         operand_in = req_operand;
         code_in    = (req_mode == MODE_ENQ) ? ST_FULL : ST_EMPTY;
      end else begin
         mode_in    = mode_ff;
         operand_in = operand_ff;
         code_in    = code_ff;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         kind_in      = mode_ff;
         last_in      = 1'b1;
         found_in     = 1'b0;
         value_in     = '0;
         unique case (cmd.out_sel)
            OUT_STAT: begin
               status_in = code_ff;
            end
            OUT_DATA: begin
               status_in = ST_OK;
               value_in  = rd_data;
               last_in   = (mode_ff != MODE_DUMP) || stat.walk_last;
            end
            OUT_FIND: begin
               status_in = ST_OK;
               found_in  = hit_ff;
            end
            default: begin
               status_in = code_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff  <= walk_idx_in;
      walk_left_ff <= walk_left_in;
      hit_ff       <= hit_in;
      mode_ff      <= mode_in;
      operand_ff   <= operand_in;
      code_ff      <= code_in;
      kind_ff      <= kind_in;
      status_ff    <= status_in;
      value_ff     <= value_in;
      found_ff     <= found_in;
      last_ff      <= last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;
   assign rsp_found  = found_ff;
   assign rsp_last   = last_ff;

endmodule
`default_nettype wire

@@ hdl/fifo_queue_with_search_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO queue with search: top level
// Bounded ring of signed 32-bit entries with enqueue, dequeue, dump and
// membership search commands.
// ----------------------------------------------------------------------------
// The block handles one command at a time; entries live in a single-port-read
// RAM and every read of a stored entry goes through that one port, one entry
// per cycle unless a dump waits for a held output register. An enqueue that
// fits is written in S_IDLE; the next command is taken in the following cycle.
// Other commands read in S_RD and S_EV, search answers from S_FIND, and an
// enqueue into a full queue or any other command on an empty queue answers
// from S_STAT. Stalls on the result side add cycles only when a beat is ready
// and the output register is still held. The last result of a command can
// wait in the output register while the next command is already accepted.
// The RAM is not cleared after reset; only occupied entries are ever read.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_core
   import fqs_pkg::*;
#(
   parameter int DEPTH = FQS_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_mode,
   input  wire logic signed [FQS_DATA_W-1:0] req_operand,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [1:0]                        rsp_status,
   output logic signed [FQS_DATA_W-1:0]      rsp_value,
   output logic                              rsp_found,
   output logic                              rsp_last
);

   fqs_cmd_type  cmd;
   fqs_stat_type stat;

   fqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   fqs_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_mode    (req_mode),
      .req_operand (req_operand),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_kind    (rsp_kind),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value),
      .rsp_found   (rsp_found),
      .rsp_last    (rsp_last)
   );

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result beat loaded over a waiting result");

   a_enq_room: assert property (@(posedge clock) disable iff (reset)
      cmd.enq_write |-> !stat.full)
      else $error("enqueue written into a full ring");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.deq_pop |-> !stat.empty)
      else $error("dequeue popped an empty ring");

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !cmd.enq_write && !cmd.latch)
      else $error("RAM read overlaps a command accept");

endmodule
`default_nettype wire
